// ===== sv/fcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpa_pkg: shared types and constants of the chunk pool allocator
// Field widths, operation and status codes, register indexes, the command
// that passes from the classifier to the list engine, and the engine states.
// ----------------------------------------------------------------------------
package fcpa_pkg;

    localparam int DEFAULT_MAX_CHUNKS = 1024;

    localparam int OP_W     = 2;
    localparam int INDEX_W  = 10;
    localparam int SIZE_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHUNKS_IN_USE = CFG_IDX_W'(1);

    localparam logic [SIZE_W-1:0]  CHUNK_BYTES_RESET   = SIZE_W'(64);
    localparam logic [COUNT_W-1:0] CHUNKS_IN_USE_RESET = COUNT_W'(1024);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST     = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_RELEASE_ALL = 2'd2,
        OP_RESERVED    = 2'd3
    } op_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FRESH     = 3'd0,
        ST_SAME      = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_IGNORED   = 3'd5
    } status_e_t;

    typedef enum logic [2:0] {
        CMD_POP,
        CMD_PUSH,
        CMD_SAME,
        CMD_TOO_LARGE,
        CMD_IGNORE,
        CMD_RELEASE_ALL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [INDEX_W-1:0]  index;
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SWEEP
    } back_state_t;

endpackage

// ===== sv/fcpa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fcpa_cfg_if: configuration write channel
// Register index and write data, moved by a valid/ready transfer.
// ----------------------------------------------------------------------------
interface fcpa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [fcpa_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [fcpa_pkg::CFG_DATA_W-1:0]  wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== sv/fcpa_req_if.sv =====
// ----------------------------------------------------------------------------
// fcpa_req_if: allocator request channel
// One request, release or release-all item per transfer.
// ----------------------------------------------------------------------------
interface fcpa_req_if;
    logic                          valid;
    logic                          ready;
    logic [fcpa_pkg::OP_W-1:0]     operation;
    logic                          holds_chunk;
    logic [fcpa_pkg::INDEX_W-1:0]  chunk_index;
    logic [fcpa_pkg::SIZE_W-1:0]   size_bytes;

    modport source (output valid, output operation, output holds_chunk,
                    output chunk_index, output size_bytes, input ready);
    modport sink   (input valid, input operation, input holds_chunk,
                    input chunk_index, input size_bytes, output ready);
endinterface

// ===== sv/fcpa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fcpa_rsp_if: allocator result channel
// Status and granted chunk, one result per transfer.
// ----------------------------------------------------------------------------
interface fcpa_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fcpa_pkg::STATUS_W-1:0]  status;
    logic                           grant_valid;
    logic [fcpa_pkg::INDEX_W-1:0]   grant_index;

    modport source (output valid, output status, output grant_valid,
                    output grant_index, input ready);
    modport sink   (input valid, input status, input grant_valid,
                    input grant_index, output ready);
endinterface

// ===== sv/fcpa_front.sv =====
// ----------------------------------------------------------------------------
// fcpa_front: configuration registers and request classifier
// Holds the chunk size and chunk count, and turns each request into one
// list command; only a release-all still needs the pool chunk count later.
// ----------------------------------------------------------------------------
module fcpa_front #(
    parameter int MAX_CHUNKS = fcpa_pkg::DEFAULT_MAX_CHUNKS,
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fcpa_cfg_if.sink             cfg,
    fcpa_req_if.sink             req,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output fcpa_pkg::cmd_t       cmd,
    output logic [CNT_W-1:0]     pool_chunks
);

    logic [fcpa_pkg::SIZE_W-1:0]  chunk_bytes_reg, chunk_bytes_next;
    logic [fcpa_pkg::COUNT_W-1:0] chunks_in_use_reg, chunks_in_use_next;
    logic                         release_ok;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        chunk_bytes_next   = chunk_bytes_reg;
        chunks_in_use_next = chunks_in_use_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.reg_index)
                fcpa_pkg::REG_CHUNK_BYTES:
                    chunk_bytes_next = cfg.wdata[fcpa_pkg::SIZE_W-1:0];
                fcpa_pkg::REG_CHUNKS_IN_USE:
                    chunks_in_use_next = cfg.wdata[fcpa_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_bytes_reg   <= fcpa_pkg::CHUNK_BYTES_RESET;
            chunks_in_use_reg <= fcpa_pkg::CHUNKS_IN_USE_RESET;
        end
        else
        begin
            chunk_bytes_reg   <= chunk_bytes_next;
            chunks_in_use_reg <= chunks_in_use_next;
        end
    end

    // Only the lowest min(chunks_in_use, MAX_CHUNKS) indices belong to the pool.
    always_comb
    begin
        if (32'(chunks_in_use_reg) < 32'(MAX_CHUNKS))
            pool_chunks = CNT_W'(chunks_in_use_reg);
        else
            pool_chunks = CNT_W'(MAX_CHUNKS);
    end

    assign release_ok = req.holds_chunk && (32'(req.chunk_index) < 32'(pool_chunks));

    always_comb
    begin
        cmd.index = req.chunk_index;
        cmd.kind  = fcpa_pkg::CMD_IGNORE;
        unique case (req.operation)
            fcpa_pkg::OP_REQUEST:
            begin
                priority if (req.size_bytes == '0)
                    cmd.kind = release_ok ? fcpa_pkg::CMD_PUSH : fcpa_pkg::CMD_IGNORE;
                else if (req.size_bytes > chunk_bytes_reg)
                    cmd.kind = fcpa_pkg::CMD_TOO_LARGE;
                else if (req.holds_chunk)
                    cmd.kind = fcpa_pkg::CMD_SAME;
                else
                    cmd.kind = fcpa_pkg::CMD_POP;
            end
            fcpa_pkg::OP_RELEASE:
                cmd.kind = release_ok ? fcpa_pkg::CMD_PUSH : fcpa_pkg::CMD_IGNORE;
            fcpa_pkg::OP_RELEASE_ALL:
                cmd.kind = fcpa_pkg::CMD_RELEASE_ALL;
            default:
                cmd.kind = fcpa_pkg::CMD_IGNORE;
        endcase
    end

    assign cmd_valid = req.valid;
    assign req.ready = cmd_ready;

endmodule

// ===== sv/fcpa_queue.sv =====
// ----------------------------------------------------------------------------
// fcpa_queue: command queue between classifier and list engine
// A short FIFO that lets either side stall without holding up the other.
// ----------------------------------------------------------------------------
module fcpa_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fcpa_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output fcpa_pkg::cmd_t  out_cmd
);

    localparam int PTR_W = fcpa_pkg::QUEUE_PTR_W;

    fcpa_pkg::cmd_t      entry_reg [fcpa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]      count_reg, count_next;
    logic                push, pop;

    assign in_ready  = (32'(count_reg) < 32'(fcpa_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + (PTR_W+1)'(1);
        else if (pop && !push)
            count_next = count_reg - (PTR_W+1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

// ===== sv/fcpa_back.sv =====
// ----------------------------------------------------------------------------
// fcpa_back: free-list engine
// Owns the list head and the link memory, carries out pops, pushes and the
// release-all sweep, and holds each result in an output register.
// ----------------------------------------------------------------------------
module fcpa_back #(
    parameter int MAX_CHUNKS = fcpa_pkg::DEFAULT_MAX_CHUNKS,
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  fcpa_pkg::cmd_t    cmd,
    input  logic [CNT_W-1:0]  pool_chunks,
    fcpa_rsp_if.source        rsp
);

    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int LINK_W = IDX_W + 1;
    localparam logic [LINK_W-1:0] NIL = {LINK_W{1'b1}};

    fcpa_pkg::back_state_t  state_reg, state_next;

    logic [LINK_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]   sweep_cnt_reg, sweep_cnt_next;

    logic [LINK_W-1:0]  link_mem [MAX_CHUNKS];
    logic [LINK_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [LINK_W-1:0]  mem_wdata;
    logic               mem_re;

    logic                           out_valid_reg;
    fcpa_pkg::status_e_t            out_status_reg;
    logic                           out_gvalid_reg;
    logic [fcpa_pkg::INDEX_W-1:0]   out_gindex_reg;

    logic                           res_load;
    fcpa_pkg::status_e_t            res_status;
    logic                           res_gvalid;
    logic [fcpa_pkg::INDEX_W-1:0]   res_gindex;

    logic  out_free, list_empty, sweep_last, take;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign list_empty = (32'(head_reg) >= 32'(MAX_CHUNKS));
    assign sweep_last = ((32'(sweep_cnt_reg) + 32'd1) == 32'(pool_chunks));
    // A command is taken only when the output register is sure to be free
    // for its result, so later states never see it occupied.
    assign take       = (state_reg == fcpa_pkg::S_IDLE) && cmd_valid && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcpa_pkg::S_IDLE:
            begin
                if (take)
                begin
                    if (cmd.kind == fcpa_pkg::CMD_POP && !list_empty)
                        state_next = fcpa_pkg::S_READ;
                    else if (cmd.kind == fcpa_pkg::CMD_RELEASE_ALL && pool_chunks != '0)
                        state_next = fcpa_pkg::S_SWEEP;
                end
            end
            fcpa_pkg::S_READ:
                state_next = fcpa_pkg::S_IDLE;
            fcpa_pkg::S_SWEEP:
            begin
                if (sweep_last)
                    state_next = fcpa_pkg::S_IDLE;
            end
            default:
                state_next = fcpa_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        head_next      = head_reg;
        sweep_cnt_next = sweep_cnt_reg;
        res_load       = 1'b0;
        res_status     = fcpa_pkg::ST_IGNORED;
        res_gvalid     = 1'b0;
        res_gindex     = '0;
        unique case (state_reg)
            fcpa_pkg::S_IDLE:
            begin
                if (take)
                begin
                    cmd_ready = 1'b1;
                    unique case (cmd.kind)
                        fcpa_pkg::CMD_SAME:
                        begin
                            res_load   = 1'b1;
                            res_status = fcpa_pkg::ST_SAME;
                            res_gvalid = 1'b1;
                            res_gindex = cmd.index;
                        end
                        fcpa_pkg::CMD_TOO_LARGE:
                        begin
                            res_load   = 1'b1;
                            res_status = fcpa_pkg::ST_TOO_LARGE;
                        end
                        fcpa_pkg::CMD_PUSH:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = IDX_W'(cmd.index);
                            mem_wdata  = head_reg;
                            head_next  = LINK_W'(cmd.index);
                            res_load   = 1'b1;
                            res_status = fcpa_pkg::ST_RELEASED;
                        end
                        fcpa_pkg::CMD_POP:
                        begin
                            if (list_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = fcpa_pkg::ST_EMPTY;
                            end
                            else
                                mem_re = 1'b1;
                        end
                        fcpa_pkg::CMD_RELEASE_ALL:
                        begin
                            sweep_cnt_next = '0;
                            if (pool_chunks == '0)
                            begin
                                head_next  = NIL;
                                res_load   = 1'b1;
                                res_status = fcpa_pkg::ST_RELEASED;
                            end
                        end
                        default:
                        begin
                            res_load   = 1'b1;
                            res_status = fcpa_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end
            fcpa_pkg::S_READ:
            begin
                head_next  = rd_data_reg;
                res_load   = 1'b1;
                res_status = fcpa_pkg::ST_FRESH;
                res_gvalid = 1'b1;
                res_gindex = fcpa_pkg::INDEX_W'(head_reg);
            end
            fcpa_pkg::S_SWEEP:
            begin
                // Chunk i links to i-1; chunk 0 ends the list.
                mem_we         = 1'b1;
                mem_waddr      = sweep_cnt_reg;
                mem_wdata      = (sweep_cnt_reg == '0) ? NIL
                                 : LINK_W'(sweep_cnt_reg) - LINK_W'(1);
                sweep_cnt_next = sweep_cnt_reg + IDX_W'(1);
                if (sweep_last)
                begin
                    head_next  = LINK_W'(sweep_cnt_reg);
                    res_load   = 1'b1;
                    res_status = fcpa_pkg::ST_RELEASED;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcpa_pkg::S_IDLE;
            head_reg      <= NIL;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            sweep_cnt_reg <= sweep_cnt_next;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_status_reg <= res_status;
            out_gvalid_reg <= res_gvalid;
            out_gindex_reg <= res_gindex;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= link_mem[IDX_W'(head_reg)];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.grant_valid = out_gvalid_reg;
    assign rsp.grant_index = out_gindex_reg;

`ifndef SYNTHESIS
    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcpa_pkg::S_READ) |-> !out_valid_reg)
        else $error("output register occupied while a pop completes");

    a_sweep_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcpa_pkg::S_SWEEP) |-> !out_valid_reg)
        else $error("output register occupied during release-all");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcpa_pkg::S_READ) |-> (32'(head_reg) < 32'(MAX_CHUNKS)))
        else $error("pop issued on an empty list");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcpa_pkg::S_SWEEP) |-> (32'(sweep_cnt_reg) < 32'(pool_chunks)))
        else $error("release-all sweep ran past the chunk count");

    a_grant_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fcpa_pkg::S_READ) |=> (out_valid_reg && out_gvalid_reg
            && out_status_reg == fcpa_pkg::ST_FRESH))
        else $error("pop did not produce a fresh grant");
`endif

endmodule

// ===== sv/fixed_chunk_pool_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator_unit: fixed-size chunk pool allocator
// Each item passes through the command queue to the engine, which loads its result
// into the output register; a pop first waits in S_READ on the registered link read.
// The engine takes one item per cycle while idle with the output register free;
// release-all holds it for min(chunks_in_use, MAX_CHUNKS) link writes.
// Reset: free list empty, chunk_bytes 64, chunks_in_use 1024; no memory clear.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator_unit #(
    parameter int MAX_CHUNKS = fcpa_pkg::DEFAULT_MAX_CHUNKS
) (
    input  logic         clk,
    input  logic         rst_n,
    fcpa_cfg_if.sink     cfg,
    fcpa_req_if.sink     req,
    fcpa_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    logic                 front_valid, front_ready;
    fcpa_pkg::cmd_t       front_cmd;
    logic                 back_valid, back_ready;
    fcpa_pkg::cmd_t       back_cmd;
    logic [CNT_W-1:0]     pool_chunks;

    fcpa_front #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready),
        .cmd         (front_cmd),
        .pool_chunks (pool_chunks)
    );

    fcpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    fcpa_back #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (back_valid),
        .cmd_ready   (back_ready),
        .cmd         (back_cmd),
        .pool_chunks (pool_chunks),
        .rsp         (rsp)
    );

endmodule
